>>> rtl/core/pgfs_pkg.sv
// Shared types and constants of the pixel gravity frame store.
`timescale 1ns / 1ps
package pgfs_pkg;

  localparam int GRID_WIDTH  = 32;
  localparam int GRID_HEIGHT = 8;
  localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;

  localparam int COLOUR_W = 24;
  localparam int MODE_W   = 2;
  localparam int COL_W    = 5;
  localparam int ROW_W    = 3;
  localparam int X_W      = $clog2(GRID_WIDTH);
  localparam int Y_W      = $clog2(GRID_HEIGHT);

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_FALL_DIRECTION  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FALL_OUT_ENABLE = 1'd1;

  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STEP  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

  typedef enum logic [1:0] {
    DIR_DOWN,
    DIR_UP,
    DIR_LEFT,
    DIR_RIGHT
  } dir_t;

  // Fixed places in the chain. A forward pass looks at the first cell, a
  // backward pass at the last one; neighbors sit at fixed distances from it.
  localparam int POS_TAP_FWD    = 0;
  localparam int POS_TAP_BWD    = CELL_COUNT - 1;
  localparam int POS_NB_UP      = CELL_COUNT - GRID_WIDTH;
  localparam int POS_NB_LEFT    = CELL_COUNT - 1;
  localparam int POS_NB_DOWN    = GRID_WIDTH - 1;
  localparam int POS_NB_RIGHT   = 0;
  localparam int POS_DST_UP     = CELL_COUNT - GRID_WIDTH - 1;
  localparam int POS_DST_LEFT   = CELL_COUNT - 2;
  localparam int POS_DST_DOWN   = GRID_WIDTH;
  localparam int POS_DST_RIGHT  = 1;

  typedef struct packed {
    logic shift;
    logic fwd;
  } shift_ctl_t;

  typedef struct packed {
    logic                en;
    logic [COLOUR_W-1:0] value;
  } ovr_t;

endpackage

>>> rtl/core/pgfs_in_if.sv
// Input item channel of the pixel gravity frame store.
`timescale 1ns / 1ps
interface pgfs_in_if;
  logic                          valid;
  logic                          ready;
  logic [pgfs_pkg::MODE_W-1:0]   mode;
  logic [pgfs_pkg::COL_W-1:0]    col_x;
  logic [pgfs_pkg::ROW_W-1:0]    row_y;
  logic [pgfs_pkg::COLOUR_W-1:0] pixel_colour;

  modport source (output valid, mode, col_x, row_y, pixel_colour, input ready);
  modport sink (input valid, mode, col_x, row_y, pixel_colour, output ready);
endinterface

>>> rtl/core/pgfs_out_if.sv
// Result item channel of the pixel gravity frame store.
`timescale 1ns / 1ps
interface pgfs_out_if;
  logic                          valid;
  logic                          ready;
  logic [pgfs_pkg::COLOUR_W-1:0] read_colour;
  logic                          any_moved;
  logic                          settled;

  modport source (output valid, read_colour, any_moved, settled, input ready);
  modport sink (input valid, read_colour, any_moved, settled, output ready);
endinterface

>>> rtl/core/pgfs_cfg_if.sv
// Configuration write channel of the pixel gravity frame store.
`timescale 1ns / 1ps
interface pgfs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pgfs_pkg::CFG_INDEX_W-1:0] index;
  logic [pgfs_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/pgfs_cell.sv
// One pixel cell of the circulating frame chain.
`timescale 1ns / 1ps
module pgfs_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  pgfs_pkg::shift_ctl_t          ctl,
  input  logic [pgfs_pkg::COLOUR_W-1:0] from_prev,
  input  logic [pgfs_pkg::COLOUR_W-1:0] from_next,
  input  pgfs_pkg::ovr_t                ovr,
  output logic [pgfs_pkg::COLOUR_W-1:0] q
);
  import pgfs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (ctl.shift) begin
      if (ovr.en) begin
        q <= ovr.value;
      end else if (ctl.fwd) begin
        q <= from_next;
      end else begin
        q <= from_prev;
      end
    end
  end
endmodule

>>> rtl/core/pgfs_settle.sv
// Gravity decision for the pixel passing the tap and its neighbor.
`timescale 1ns / 1ps
module pgfs_settle (
  input  logic                          step,
  input  logic                          at_edge,
  input  logic                          fall_out,
  input  logic [pgfs_pkg::COLOUR_W-1:0] here,
  input  logic [pgfs_pkg::COLOUR_W-1:0] nb,
  output logic [pgfs_pkg::COLOUR_W-1:0] here_new,
  output logic [pgfs_pkg::COLOUR_W-1:0] nb_new,
  output logic                          nb_wr,
  output logic                          moved
);
  import pgfs_pkg::*;

  always_comb begin
    here_new = here;
    nb_new   = nb;
    nb_wr    = 1'b0;
    moved    = 1'b0;
    if (step && (here != '0)) begin
      if (at_edge) begin
        if (fall_out) begin
          here_new = '0;
          moved    = 1'b1;
        end
      end else if (nb == '0) begin
        nb_new   = here;
        nb_wr    = 1'b1;
        here_new = '0;
        moved    = 1'b1;
      end
    end
  end
endmodule

>>> rtl/core/pixel_gravity_frame_step_top.sv
// Top level of the pixel gravity frame store.
`timescale 1ns / 1ps
// The frame is held in a ring of pixel cells that rotates one place per clock
// while an item is worked on. Every item (write, read, gravity step or unused
// mode) takes one full turn of the ring past a single tap, plus an accept and a
// result hand-off. A step turns the ring backward for down and right and forward
// otherwise, so the pixel at the tap always sees a neighbor that was already
// settled. Reset clears the whole frame. A new item is accepted while the
// previous result still waits in the output register.
module pixel_gravity_frame_step_top (
  input logic      clk,
  input logic      rst,
  pgfs_in_if.sink  req,
  pgfs_out_if.source rsp,
  pgfs_cfg_if.sink cfg
);
  import pgfs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t                state;
  dir_t                  fall_dir;
  logic                  fall_out;
  logic                  fwd;
  logic [MODE_W-1:0]     mode;
  logic [COL_W-1:0]      col;
  logic [ROW_W-1:0]      row;
  logic [COLOUR_W-1:0]   colour;
  logic [X_W-1:0]        x;
  logic [Y_W-1:0]        y;
  logic                  moved_acc;
  logic [COLOUR_W-1:0]   rd_val;

  logic [COLOUR_W-1:0]   cell_q [CELL_COUNT];
  ovr_t                  ovr [CELL_COUNT];
  shift_ctl_t            shift_ctl;

  logic [COLOUR_W-1:0]   here;
  logic [COLOUR_W-1:0]   nb;
  logic [COLOUR_W-1:0]   here_new;
  logic [COLOUR_W-1:0]   nb_new;
  logic [COLOUR_W-1:0]   tap_val;
  logic                  nb_wr;
  logic                  moved;
  logic                  at_edge;
  logic                  is_step;
  logic                  addr_hit;
  logic                  last;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == ST_IDLE);

  assign shift_ctl.shift = (state == ST_RUN);
  assign shift_ctl.fwd   = fwd;

  assign is_step  = (mode == MODE_STEP);
  assign addr_hit = ((COL_W + X_W)'(x) == (COL_W + X_W)'(col)) &&
                    ((ROW_W + Y_W)'(y) == (ROW_W + Y_W)'(row));
  assign last     = fwd ? ((x == X_W'(GRID_WIDTH - 1)) && (y == Y_W'(GRID_HEIGHT - 1)))
                        : ((x == '0) && (y == '0));
  assign here     = fwd ? cell_q[POS_TAP_FWD] : cell_q[POS_TAP_BWD];

  always_comb begin
    unique case (fall_dir)
      DIR_DOWN: begin
        at_edge = (y == Y_W'(GRID_HEIGHT - 1));
        nb      = cell_q[POS_NB_DOWN];
      end
      DIR_UP: begin
        at_edge = (y == '0);
        nb      = cell_q[POS_NB_UP];
      end
      DIR_LEFT: begin
        at_edge = (x == '0);
        nb      = cell_q[POS_NB_LEFT];
      end
      DIR_RIGHT: begin
        at_edge = (x == X_W'(GRID_WIDTH - 1));
        nb      = cell_q[POS_NB_RIGHT];
      end
    endcase
  end

  pgfs_settle u_settle (
    .step     (is_step),
    .at_edge  (at_edge),
    .fall_out (fall_out),
    .here     (here),
    .nb       (nb),
    .here_new (here_new),
    .nb_new   (nb_new),
    .nb_wr    (nb_wr),
    .moved    (moved)
  );

  always_comb begin
    tap_val = here_new;
    if ((mode == MODE_WRITE) && addr_hit) begin
      tap_val = colour;
    end
  end

  // The tap cell always reloads its (possibly changed) pixel; the neighbor
  // destination is only overridden when a pixel drops into it.
  always_comb begin
    for (int k = 0; k < CELL_COUNT; k++) begin
      ovr[k] = '0;
    end
    if (fwd) begin
      ovr[POS_TAP_BWD].en    = 1'b1;
      ovr[POS_TAP_BWD].value = tap_val;
    end else begin
      ovr[POS_TAP_FWD].en    = 1'b1;
      ovr[POS_TAP_FWD].value = tap_val;
    end
    if (nb_wr) begin
      unique case (fall_dir)
        DIR_DOWN: begin
          ovr[POS_DST_DOWN].en    = 1'b1;
          ovr[POS_DST_DOWN].value = nb_new;
        end
        DIR_UP: begin
          ovr[POS_DST_UP].en    = 1'b1;
          ovr[POS_DST_UP].value = nb_new;
        end
        DIR_LEFT: begin
          ovr[POS_DST_LEFT].en    = 1'b1;
          ovr[POS_DST_LEFT].value = nb_new;
        end
        DIR_RIGHT: begin
          ovr[POS_DST_RIGHT].en    = 1'b1;
          ovr[POS_DST_RIGHT].value = nb_new;
        end
      endcase
    end
  end

  for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
    pgfs_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (shift_ctl),
      .from_prev (cell_q[(k + CELL_COUNT - 1) % CELL_COUNT]),
      .from_next (cell_q[(k + 1) % CELL_COUNT]),
      .ovr       (ovr[k]),
      .q         (cell_q[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fall_dir <= DIR_DOWN;
      fall_out <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FALL_DIRECTION:  fall_dir <= dir_t'(cfg.data[1:0]);
        REG_FALL_OUT_ENABLE: fall_out <= cfg.data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp.valid <= 1'b0;
      fwd       <= 1'b1;
    end else begin
      // In the done state the hand-off below decides the output valid itself.
      if (rsp.valid && rsp.ready && (state != ST_DONE)) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            mode      <= req.mode;
            col       <= req.col_x;
            row       <= req.row_y;
            colour    <= req.pixel_colour;
            moved_acc <= 1'b0;
            rd_val    <= '0;
            if ((req.mode == MODE_STEP) &&
                ((fall_dir == DIR_DOWN) || (fall_dir == DIR_RIGHT))) begin
              fwd <= 1'b0;
              x   <= X_W'(GRID_WIDTH - 1);
              y   <= Y_W'(GRID_HEIGHT - 1);
            end else begin
              fwd <= 1'b1;
              x   <= '0;
              y   <= '0;
            end
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (moved) begin
            moved_acc <= 1'b1;
          end
          if ((mode == MODE_READ) && addr_hit) begin
            rd_val <= here;
          end
          if (fwd) begin
            if (x == X_W'(GRID_WIDTH - 1)) begin
              x <= '0;
              y <= y + Y_W'(1);
            end else begin
              x <= x + X_W'(1);
            end
          end else begin
            if (x == '0) begin
              x <= X_W'(GRID_WIDTH - 1);
              y <= y - Y_W'(1);
            end else begin
              x <= x - X_W'(1);
            end
          end
          if (last) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid       <= 1'b1;
            rsp.read_colour <= (mode == MODE_READ) ? rd_val : '0;
            rsp.any_moved   <= is_step && moved_acc;
            rsp.settled     <= is_step && !moved_acc;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
